// ===== sv/dfs_pkg.sv =====
// ============================================================================
// dfs_pkg
// Shared types and constants for the depth-first topological sort block.
// ============================================================================
package dfs_pkg;

    localparam int MaxNodes = 64;
    localparam int MaxEdges = 256;
    localparam int NodeW    = $clog2(MaxNodes);
    localparam int EdgeW    = $clog2(MaxEdges);
    localparam int EcntW    = $clog2(MaxEdges + 1);
    localparam int FcntW    = $clog2(MaxNodes + 1);

    typedef enum logic [1:0] {
        REQ_ADD_NODE = 2'd0,
        REQ_ADD_EDGE = 2'd1,
        REQ_SORT     = 2'd2,
        REQ_NONE     = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_DUP     = 3'd1,
        ST_UNKNOWN = 3'd2,
        ST_FULL    = 3'd3,
        ST_ENTRY   = 3'd4,
        ST_EMPTY   = 3'd5
    } status_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [5:0] node_id;
        logic [5:0] target_id;
    } in_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [5:0] order_node;
        logic       last;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EDGE_RD,
        S_EDGE_WR,
        S_EDGE_NEW,
        S_ROOT,
        S_PUSH,
        S_TOP,
        S_EDGE_FETCH,
        S_EDGE_USE,
        S_EMIT,
        S_REPLY
    } state_t;

    // One frame of the walk stack.
    typedef struct packed {
        logic [NodeW-1:0] node;
        logic [EdgeW-1:0] cur;
        logic             more;
    } frame_t;

endpackage

// ===== sv/dfs_topological_order_top.sv =====
// ============================================================================
// dfs_topological_order_top
// Graph builder with depth-first reverse post-order sort.
// ============================================================================
// An add-node request goes straight from idle to the reply state. An add-edge
// request goes through the edge read state to the reply when it is rejected
// or starts a node's list, and also through the link and new-entry states when
// it is appended to an existing list (read the old tail entry, patch its link,
// write the new entry). A sort scans every id as a root, pushes each new node,
// fetches and uses each edge followed, and emits the order items; output
// stalls hold it. The single port of the edge memory makes an append use
// separate read, patch and write states. Node flags are flip-flops cleared at
// reset; edge, list and stack memories need no clearing pass.
module dfs_topological_order_top
    import dfs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    state_t state_reg, state_next;
    in_item_t req_reg, req_next;
    logic [MaxNodes-1:0] present_reg, present_next;
    logic [MaxNodes-1:0] visited_reg, visited_next;
    logic [MaxNodes-1:0] nonempty_reg, nonempty_next;
    logic [EcntW-1:0] used_reg, used_next;
    logic [FcntW-1:0] fcnt_reg, fcnt_next;
    logic [FcntW-1:0] sp_reg, sp_next;
    logic [NodeW:0]   root_reg, root_next;
    frame_t           top_reg, top_next;
    logic [NodeW-1:0] dest_reg, dest_next;
    logic             full_reg, full_next;
    logic             ovalid_reg, ovalid_next;
    out_item_t        odata_reg, odata_next;
    logic             popped_reg;
    frame_t           top_live;
    logic             pop;

    // Edge memory: destination and link per entry.
    logic                       e_we;
    logic [EdgeW-1:0]           e_addr;
    logic [NodeW+EdgeW-1:0]     e_wdata, e_rdata;
    // List memory: head and tail edge index per node.
    logic                       l_we;
    logic [NodeW-1:0]           l_addr;
    logic [2*EdgeW-1:0]         l_wdata, l_rdata;
    logic [EdgeW-1:0]           l_head, l_tail;
    // Walk stack memory.
    logic                       w_we;
    logic [NodeW-1:0]           w_addr;
    frame_t                     w_wdata, w_rdata;
    // Finish stack memory.
    logic                       f_we;
    logic [NodeW-1:0]           f_addr;
    logic [NodeW-1:0]           f_wdata, f_rdata;

    dfs_ram #(.Width(NodeW+EdgeW), .Depth(MaxEdges)) u_edge (
        .clk(clk), .we(e_we), .addr(e_addr), .wdata(e_wdata), .rdata(e_rdata));
    dfs_ram #(.Width(2*EdgeW), .Depth(MaxNodes)) u_list (
        .clk(clk), .we(l_we), .addr(l_addr), .wdata(l_wdata), .rdata(l_rdata));
    dfs_ram #(.Width($bits(frame_t)), .Depth(MaxNodes)) u_walk (
        .clk(clk), .we(w_we), .addr(w_addr), .wdata(w_wdata), .rdata(w_rdata));
    dfs_ram #(.Width(NodeW), .Depth(MaxNodes)) u_fin (
        .clk(clk), .we(f_we), .addr(f_addr), .wdata(f_wdata), .rdata(f_rdata));

    logic [NodeW-1:0] a_id, b_id;
    logic             edge_ok;
    logic             out_free;

    assign a_id     = req_reg.node_id[NodeW-1:0];
    assign b_id     = req_reg.target_id[NodeW-1:0];
    assign edge_ok  = present_reg[a_id] && present_reg[b_id];
    assign out_free = !ovalid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;
    assign l_head   = l_rdata[2*EdgeW-1:EdgeW];
    assign l_tail   = l_rdata[EdgeW-1:0];

    // After a pop, the frame below arrives from the walk stack in the next cycle.
    assign top_live = popped_reg ? w_rdata : top_reg;
    assign pop      = (state_reg == S_TOP) && (sp_reg != '0) && !top_live.more;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            present_reg  <= '0;
            visited_reg  <= '0;
            nonempty_reg <= '0;
            used_reg     <= '0;
            fcnt_reg     <= '0;
            sp_reg       <= '0;
            root_reg     <= '0;
            ovalid_reg   <= 1'b0;
            popped_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            present_reg  <= present_next;
            visited_reg  <= visited_next;
            nonempty_reg <= nonempty_next;
            used_reg     <= used_next;
            fcnt_reg     <= fcnt_next;
            sp_reg       <= sp_next;
            root_reg     <= root_next;
            ovalid_reg   <= ovalid_next;
            popped_reg   <= pop;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        top_reg   <= top_next;
        dest_reg  <= dest_next;
        full_reg  <= full_next;
        odata_reg <= odata_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (req_t'(in_data.req_type))
                        REQ_ADD_NODE: state_next = S_REPLY;
                        REQ_ADD_EDGE: state_next = S_EDGE_RD;
                        REQ_SORT:     state_next = S_ROOT;
                        default:      state_next = S_IDLE;
                    endcase
                end
            end
            S_EDGE_RD:
            begin
                if (edge_ok && used_reg != EcntW'(MaxEdges) && nonempty_reg[a_id])
                begin
                    state_next = S_EDGE_WR;
                end
                else
                begin
                    state_next = S_REPLY;
                end
            end
            S_EDGE_WR: state_next = S_EDGE_NEW;
            S_EDGE_NEW: state_next = S_REPLY;
            S_ROOT:
            begin
                if (root_reg == (NodeW+1)'(MaxNodes))
                begin
                    state_next = S_EMIT;
                end
                else if (present_reg[root_reg[NodeW-1:0]] && !visited_reg[root_reg[NodeW-1:0]])
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH: state_next = S_TOP;
            S_TOP:
            begin
                if (sp_reg == '0)
                begin
                    state_next = S_ROOT;
                end
                else if (top_live.more)
                begin
                    state_next = S_EDGE_FETCH;
                end
            end
            S_EDGE_FETCH: state_next = S_EDGE_USE;
            S_EDGE_USE:
            begin
                state_next = visited_reg[e_rdata[NodeW+EdgeW-1:EdgeW]] ? S_TOP : S_PUSH;
            end
            S_EMIT:
            begin
                if (out_free && (fcnt_reg <= FcntW'(1)))
                begin
                    state_next = S_IDLE;
                end
            end
            S_REPLY:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        req_next      = req_reg;
        present_next  = present_reg;
        visited_next  = visited_reg;
        nonempty_next = nonempty_reg;
        used_next     = used_reg;
        fcnt_next     = fcnt_reg;
        sp_next       = sp_reg;
        root_next     = root_reg;
        top_next      = top_reg;
        dest_next     = dest_reg;
        full_next     = full_reg;
        ovalid_next   = ovalid_reg && !out_ready;
        odata_next    = odata_reg;
        e_we          = 1'b0;
        e_addr        = top_reg.cur;
        e_wdata       = '0;
        l_we          = 1'b0;
        l_addr        = a_id;
        l_wdata       = {l_head, used_reg[EdgeW-1:0]};
        w_we          = 1'b0;
        w_addr        = sp_reg[NodeW-1:0];
        w_wdata       = top_reg;
        f_we          = 1'b0;
        f_addr        = fcnt_reg[NodeW-1:0];
        f_wdata       = top_reg.node;
        unique case (state_reg)
            S_IDLE:
            begin
                req_next  = in_data;
                root_next = '0;
                sp_next   = '0;
                l_addr    = in_data.node_id[NodeW-1:0];
                if (in_valid && req_t'(in_data.req_type) == REQ_SORT)
                begin
                    visited_next = '0;
                    fcnt_next    = '0;
                end
            end
            S_EDGE_RD:
            begin
                // The source node's list entry was read while idle.
                full_next = (used_reg == EcntW'(MaxEdges));
                if (edge_ok && used_reg != EcntW'(MaxEdges))
                begin
                    if (nonempty_reg[a_id])
                    begin
                        e_addr = l_tail;
                    end
                    else
                    begin
                        e_we    = 1'b1;
                        e_addr  = used_reg[EdgeW-1:0];
                        e_wdata = {b_id, EdgeW'(0)};
                        l_we    = 1'b1;
                        l_wdata = {used_reg[EdgeW-1:0], used_reg[EdgeW-1:0]};
                        nonempty_next[a_id] = 1'b1;
                        used_next = used_reg + EcntW'(1);
                    end
                end
            end
            S_EDGE_WR:
            begin
                // Link the old tail entry to the new one, keeping its destination.
                e_we    = 1'b1;
                e_addr  = l_tail;
                e_wdata = {e_rdata[NodeW+EdgeW-1:EdgeW], used_reg[EdgeW-1:0]};
            end
            S_EDGE_NEW:
            begin
                e_we      = 1'b1;
                e_addr    = used_reg[EdgeW-1:0];
                e_wdata   = {b_id, EdgeW'(0)};
                l_we      = 1'b1;
                l_wdata   = {l_head, used_reg[EdgeW-1:0]};
                used_next = used_reg + EcntW'(1);
            end
            S_ROOT:
            begin
                l_addr = root_reg[NodeW-1:0];
                if (root_reg != (NodeW+1)'(MaxNodes))
                begin
                    dest_next = root_reg[NodeW-1:0];
                    root_next = root_reg + (NodeW+1)'(1);
                end
                if (root_reg == (NodeW+1)'(MaxNodes) && fcnt_reg != '0)
                begin
                    f_addr = fcnt_reg[NodeW-1:0] - NodeW'(1);
                end
            end
            S_PUSH:
            begin
                // Save the current top, then the new node becomes the top.
                if (sp_reg != '0)
                begin
                    w_we   = 1'b1;
                    w_addr = sp_reg[NodeW-1:0] - NodeW'(1);
                end
                top_next.node = dest_reg;
                top_next.more = nonempty_reg[dest_reg];
                top_next.cur  = l_head;
                visited_next[dest_reg] = 1'b1;
                sp_next = sp_reg + FcntW'(1);
            end
            S_TOP:
            begin
                top_next = top_live;
                if (sp_reg != '0)
                begin
                    if (top_live.more)
                    begin
                        e_addr = top_live.cur;
                    end
                    else
                    begin
                        f_we      = 1'b1;
                        f_wdata   = top_live.node;
                        fcnt_next = fcnt_reg + FcntW'(1);
                        sp_next   = sp_reg - FcntW'(1);
                        w_addr    = sp_reg[NodeW-1:0] - NodeW'(2);
                    end
                end
            end
            S_EDGE_FETCH:
            begin
                e_addr = top_reg.cur;
                l_addr = top_reg.node;
            end
            S_EDGE_USE:
            begin
                dest_next = e_rdata[NodeW+EdgeW-1:EdgeW];
                l_addr    = e_rdata[NodeW+EdgeW-1:EdgeW];
                if (top_reg.cur == l_tail)
                begin
                    top_next.more = 1'b0;
                end
                else
                begin
                    top_next.cur = e_rdata[EdgeW-1:0];
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    if (fcnt_reg == '0)
                    begin
                        odata_next = '{status: ST_EMPTY, order_node: '0, last: 1'b1};
                    end
                    else
                    begin
                        odata_next = '{status: ST_ENTRY, order_node: 6'(f_rdata),
                                       last: (fcnt_reg == FcntW'(1))};
                        fcnt_next = fcnt_reg - FcntW'(1);
                    end
                    f_addr = fcnt_reg[NodeW-1:0] - NodeW'(2);
                end
                else
                begin
                    f_addr = fcnt_reg[NodeW-1:0] - NodeW'(1);
                end
            end
            S_REPLY:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    odata_next.order_node = '0;
                    odata_next.last = 1'b1;
                    if (req_t'(req_reg.req_type) == REQ_ADD_NODE)
                    begin
                        if (present_reg[a_id])
                        begin
                            odata_next.status = ST_DUP;
                        end
                        else
                        begin
                            odata_next.status = ST_OK;
                            present_next[a_id] = 1'b1;
                        end
                    end
                    else if (!edge_ok)
                    begin
                        odata_next.status = ST_UNKNOWN;
                    end
                    else if (full_reg)
                    begin
                        odata_next.status = ST_FULL;
                    end
                    else
                    begin
                        odata_next.status = ST_OK;
                    end
                end
            end
            default: ;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUSH) |=> visited_reg[$past(dest_reg)])
        else $error("pushed node not marked visited");
    assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= EcntW'(MaxEdges))
        else $error("edge count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= FcntW'(MaxNodes))
        else $error("walk stack overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        fcnt_reg <= FcntW'(MaxNodes))
        else $error("finish stack overflow");

endmodule

// ===== sv/dfs_ram.sv =====
// ============================================================================
// dfs_ram
// Generic single-port synchronous RAM with a registered read.
// ============================================================================
module dfs_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== tb/dfs_topological_order_top_tb.sv =====
// ============================================================================
// dfs_topological_order_top_tb
// Self-checking testbench for the depth-first topological sort block. Sends
// node, edge and sort requests, predicts every result with a behavioral graph
// model, and compares each result item field by field under random idling.
// ============================================================================
`timescale 1ns / 1ps

module dfs_topological_order_top_tb
    import dfs_pkg::*;
();

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    dfs_topological_order_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    localparam int CycleLimit = 2000000;

    // Graph model state.
    bit        node_exists[MaxNodes];
    int        adj_list[MaxNodes][$];
    int        edge_total;
    bit        seen[MaxNodes];
    int        post_order[$];

    out_item_t expected_results[$];
    int        error_count;
    int        cycle_count;
    int        send_idle_pct;
    int        recv_stall_pct;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    function automatic out_item_t make_result(status_t st, int node, bit fin);
        out_item_t r;
        r.status     = st;
        r.order_node = node[5:0];
        r.last       = fin;
        return r;
    endfunction

    // Iterative walk; each frame keeps the next edge index in its node's list.
    function automatic void walk_graph(int root);
        int stk_node[$];
        int stk_pos[$];
        int n;
        int p;
        int d;
        stk_node.push_back(root);
        stk_pos.push_back(0);
        seen[root] = 1'b1;
        while (stk_node.size() > 0)
        begin
            n = stk_node[$];
            p = stk_pos[$];
            if (p < adj_list[n].size())
            begin
                stk_pos[$] = p + 1;
                d = adj_list[n][p];
                if (!seen[d])
                begin
                    seen[d] = 1'b1;
                    stk_node.push_back(d);
                    stk_pos.push_back(0);
                end
            end
            else
            begin
                post_order.push_back(n);
                void'(stk_node.pop_back());
                void'(stk_pos.pop_back());
            end
        end
    endfunction

    function automatic void predict_request(in_item_t it);
        int a;
        int b;
        a = it.node_id;
        b = it.target_id;
        case (req_t'(it.req_type))
            REQ_ADD_NODE:
            begin
                if (node_exists[a])
                    expected_results.push_back(make_result(ST_DUP, 0, 1'b1));
                else
                begin
                    node_exists[a] = 1'b1;
                    expected_results.push_back(make_result(ST_OK, 0, 1'b1));
                end
            end
            REQ_ADD_EDGE:
            begin
                if (!node_exists[a] || !node_exists[b])
                    expected_results.push_back(make_result(ST_UNKNOWN, 0, 1'b1));
                else if (edge_total >= MaxEdges)
                    expected_results.push_back(make_result(ST_FULL, 0, 1'b1));
                else
                begin
                    adj_list[a].push_back(b);
                    edge_total++;
                    expected_results.push_back(make_result(ST_OK, 0, 1'b1));
                end
            end
            REQ_SORT:
            begin
                foreach (seen[i]) seen[i] = 1'b0;
                post_order.delete();
                for (int i = 0; i < MaxNodes; i++)
                    if (node_exists[i] && !seen[i]) walk_graph(i);
                if (post_order.size() == 0)
                    expected_results.push_back(make_result(ST_EMPTY, 0, 1'b1));
                else
                    for (int i = post_order.size() - 1; i >= 0; i--)
                        expected_results.push_back(
                            make_result(ST_ENTRY, post_order[i], i == 0));
            end
            default: ;
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the accept.
    task automatic send_request(input req_t rt, input int a, input int b);
        in_item_t it;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        it.req_type  = rt;
        it.node_id   = a[5:0];
        it.target_id = b[5:0];
        in_data  <= it;
        in_valid <= 1'b1;
        predict_request(it);
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // Receiver: random stall pattern driven at the falling edge.
    always @(negedge clk)
        if (rst_n) out_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch($sformatf("unexpected result %p", out_data));
            else
            begin
                out_item_t e;
                e = expected_results.pop_front();
                if (out_data.status !== e.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              out_data.status, e.status));
                if (out_data.order_node !== e.order_node)
                    report_mismatch($sformatf("order_node %0d, want %0d",
                                              out_data.order_node, e.order_node));
                if (out_data.last !== e.last)
                    report_mismatch($sformatf("last %0d, want %0d",
                                              out_data.last, e.last));
            end
        end
    end

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_results.size() > 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic test_directed();
        send_request(REQ_SORT, 0, 0);          // empty graph
        send_request(REQ_ADD_EDGE, 0, 63);     // unknown ends
        send_request(REQ_NONE, 5, 5);          // ignored request
        send_request(REQ_ADD_NODE, 0, 0);
        send_request(REQ_ADD_NODE, 63, 63);
        send_request(REQ_ADD_NODE, 0, 0);      // duplicate
        send_request(REQ_ADD_NODE, 5, 0);
        send_request(REQ_ADD_NODE, 42, 21);
        send_request(REQ_ADD_EDGE, 63, 0);
        send_request(REQ_ADD_EDGE, 0, 5);
        send_request(REQ_ADD_EDGE, 0, 42);
        send_request(REQ_ADD_EDGE, 5, 5);      // self loop
        send_request(REQ_ADD_EDGE, 42, 0);     // cycle
        send_request(REQ_ADD_EDGE, 0, 21);     // unknown target
        send_request(REQ_ADD_EDGE, 21, 0);     // unknown source
        send_request(REQ_SORT, 63, 42);
        drain_results();
    endtask

    // Builds random graphs and sorts them; occasional noise requests.
    task automatic test_random(input int count);
        for (int k = 0; k < count; k++)
        begin
            int r;
            r = $urandom_range(99);
            if (r < 35)
                send_request(REQ_ADD_NODE, $urandom_range(63), $urandom_range(63));
            else if (r < 85)
                send_request(REQ_ADD_EDGE, $urandom_range(63), $urandom_range(63));
            else if (r < 95)
                send_request(REQ_SORT, $urandom_range(63), $urandom_range(63));
            else
                send_request(REQ_NONE, $urandom_range(63), $urandom_range(63));
        end
        send_request(REQ_SORT, 0, 0);
        drain_results();
    endtask

    // Fills the edge store between present nodes, then overflows it.
    task automatic test_full_store();
        int ids[$];
        int a;
        int b;
        for (int i = 0; i < MaxNodes; i++)
            if (node_exists[i]) ids.push_back(i);
        while (edge_total < MaxEdges)
        begin
            a = ids[$urandom_range(ids.size() - 1)];
            b = ids[$urandom_range(ids.size() - 1)];
            send_request(REQ_ADD_EDGE, a, b);
        end
        send_request(REQ_ADD_EDGE, ids[0], ids[ids.size() - 1]);
        send_request(REQ_SORT, 0, 0);
        drain_results();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        out_ready      = 1'b0;
        error_count    = 0;
        cycle_count    = 0;
        edge_total     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        send_idle_pct = 59;
        test_random(15);
        send_idle_pct = 0;
        recv_stall_pct = 59;
        test_random(15);
        send_idle_pct = 34;
        recv_stall_pct = 34;
        test_random(15);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_full_store();

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
